### rtl/lsws_pkg.sv
package lsws_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 5;

  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP_WAIT,
    BK_SCAN
  } bk_state_t;

  typedef struct packed {
    op_t                  op;
    logic [WordWidth-1:0] value;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_if_t;

endpackage

### rtl/lifo_stack_with_search_core.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   req_type, value
// out      output     out_valid / out_ready status, removed_value, found, is_empty,
//                                           top_value, entry_count
//
// push, error cases, undefined requests and a pop down to empty finish straight from idle in the
// back end; a pop that leaves entries also passes through BK_POP_WAIT (stack ram read of the new top)
// a search scans entries from the bottom, one ram read a cycle, until a hit or the top entry
// the back end starts the next item only once the result is taken and out_valid has dropped
// a two-item queue takes input while the result register waits on out_ready
// rst is synchronous; the stack ram needs no clearing pass
module lifo_stack_with_search_core
  import lsws_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic signed [WordWidth-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic signed [WordWidth-1:0] removed_value,
  output logic                        found,
  output logic                        is_empty,
  output logic signed [WordWidth-1:0] top_value,
  output logic [CountWidth-1:0]       entry_count
);

  q_if_t q;
  logic  take;

  lsws_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .value   (value),
    .q       (q),
    .take    (take)
  );

  lsws_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q            (q),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .removed_value(removed_value),
    .found        (found),
    .is_empty     (is_empty),
    .top_value    (top_value),
    .entry_count  (entry_count)
  );

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_POP_EMPTY) |-> is_empty && (removed_value == '0))
    else $error("pop error reported on a non-empty stack");

  a_found_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !is_empty && (status == ST_OK))
    else $error("search hit on an empty stack");

  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |-> q.valid)
    else $error("back end took an item from an empty queue");

  a_full_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q.valid)
    else $error("input stalled with an empty queue");

endmodule

### rtl/lsws_ram.sv
module lsws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lsws_front.sv
module lsws_front
  import lsws_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  req_type,
  input  logic signed [WordWidth-1:0] value,
  output q_if_t                       q,
  input  logic                        take
);

  q_item_t    slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  op_t        op_class;
  logic       push;

  always_comb begin
    case (req_type)
      REQ_PUSH:   op_class = OP_PUSH;
      REQ_POP:    op_class = OP_POP;
      REQ_SEARCH: op_class = OP_SEARCH;
      default:    op_class = OP_NOP;
    endcase
  end

  assign in_ready     = (count != 2'd2);
  assign push         = in_valid && in_ready;
  assign q.valid      = (count != 2'd0);
  assign q.item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].op    <= op_class;
      slots[wr_ptr].value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/lsws_back.sv
module lsws_back
  import lsws_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  q_if_t                        q,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic signed [WordWidth-1:0]  removed_value,
  output logic                         found,
  output logic                         is_empty,
  output logic signed [WordWidth-1:0]  top_value,
  output logic [CountWidth-1:0]        entry_count
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(STACK_DEPTH);

  bk_state_t            state;
  bk_state_t            state_next;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;
  logic [WordWidth-1:0] top;
  logic [WordWidth-1:0] top_next;
  logic [WordWidth-1:0] key;
  logic [WordWidth-1:0] key_next;
  logic [AW-1:0]        scan_idx;
  logic [AW-1:0]        scan_idx_next;
  logic [1:0]           status_next;
  logic [WordWidth-1:0] removed_next;
  logic                 found_next;
  logic                 emit;
  logic                 start;
  logic                 mem_we;
  logic [AW-1:0]        rd_addr;
  logic [WordWidth-1:0] rdata;
  logic                 hit;
  logic                 last;

  lsws_ram #(
    .WIDTH(WordWidth),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(AW'(fill)),
    .wdata(q.item.value),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign start = (state == BK_IDLE) && q.valid && !out_valid;
  assign hit   = (rdata == key);
  assign last  = (FW'(scan_idx) == (fill - FW'(1)));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (start) begin
          case (q.item.op)
            OP_POP: begin
              if (fill > FW'(1)) begin
                state_next = BK_POP_WAIT;
              end
            end
            OP_SEARCH: begin
              if (fill != '0) begin
                state_next = BK_SCAN;
              end
            end
            default: state_next = BK_IDLE;
          endcase
        end
      end
      BK_POP_WAIT: state_next = BK_IDLE;
      BK_SCAN: begin
        if (hit || last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    take          = 1'b0;
    emit          = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    fill_next     = fill;
    top_next      = top;
    key_next      = key;
    scan_idx_next = scan_idx;
    status_next   = status;
    removed_next  = removed_value;
    found_next    = found;
    case (state)
      BK_IDLE: begin
        if (start) begin
          take         = 1'b1;
          key_next     = q.item.value;
          status_next  = ST_OK;
          removed_next = '0;
          found_next   = 1'b0;
          case (q.item.op)
            OP_PUSH: begin
              emit = 1'b1;
              if (fill == FULL) begin
                status_next = ST_PUSH_FULL;
              end else begin
                mem_we    = 1'b1;
                fill_next = fill + FW'(1);
                top_next  = q.item.value;
              end
            end
            OP_POP: begin
              if (fill == '0) begin
                status_next = ST_POP_EMPTY;
                emit        = 1'b1;
              end else begin
                removed_next = top;
                fill_next    = fill - FW'(1);
                if (fill == FW'(1)) begin
                  top_next = '0;
                  emit     = 1'b1;
                end else begin
                  rd_addr = AW'(fill - FW'(2));
                end
              end
            end
            OP_SEARCH: begin
              if (fill == '0) begin
                emit = 1'b1;
              end else begin
                rd_addr       = '0;
                scan_idx_next = '0;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      BK_POP_WAIT: begin
        top_next = rdata;
        emit     = 1'b1;
      end
      BK_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          emit       = 1'b1;
        end else if (last) begin
          emit = 1'b1;
        end else begin
          scan_idx_next = scan_idx + AW'(1);
          rd_addr       = scan_idx + AW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      fill      <= '0;
      top       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      top   <= top_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key           <= key_next;
    scan_idx      <= scan_idx_next;
    status        <= status_next;
    removed_value <= removed_next;
    found         <= found_next;
  end

  assign is_empty    = (fill == '0);
  assign top_value   = top;
  assign entry_count = CountWidth'(fill);

endmodule
